// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands shared by the RTL; each expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gcc_pkg.sv =====
`default_nettype none

package gcc_pkg;

    localparam int MAX_VERTICES_DEF = 64;  // default vertex capacity
    localparam int ROW_LIMIT        = 64;  // widest adjacency row supported
    localparam int VTX_W            = 6;   // vertex index field
    localparam int COLOR_W          = 6;   // color field
    localparam int CNT_W            = 7;   // vertex count and color count fields
    localparam int VCOUNT_RST       = 64;  // vertex count after reset

endpackage

`default_nettype wire

// ===== rtl/core/gcc_ram.sv =====
`default_nettype none

module gcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/greedy_graph_coloring_core.sv =====
// Edge word: the row is read at accept and written back in the busy state after it;
// no new edge word is taken while busy. Coloring after the last edge visits each
// vertex in order: row read, earlier neighbors latched, a serial walk over earlier
// vertices through the single color RAM read port, then the free color search.
// Result words come one per vertex, each on a one-cycle strobe; the receiver cannot stall.
// Synchronous active-low reset clears the sequencer, row valid bits and strobe; the
// vertex count resets to 64. No clearing pass: the matrix is emptied by its valid bits.
`default_nettype none
`include "assert_macros.svh"

module greedy_graph_coloring_core #(
    parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // edge words
    input  logic                        start,
    output logic                        busy,
    input  logic [gcc_pkg::VTX_W-1:0]   i_vertex_a,
    input  logic [gcc_pkg::VTX_W-1:0]   i_vertex_b,
    input  logic                        i_last_edge,
    // vertex count register
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gcc_pkg::CNT_W-1:0]   i_cfg_data,
    // result words
    output logic                        o_strobe,
    output logic [gcc_pkg::VTX_W-1:0]   o_vertex_index,
    output logic [gcc_pkg::COLOR_W-1:0] o_vertex_color,
    output logic [gcc_pkg::CNT_W-1:0]   o_color_count,
    output logic                        o_last_result
);

    import gcc_pkg::*;

    // Rows never exceed ROW_LIMIT bits, so capacity above that is unused.
    localparam int DEPTH = (MAX_VERTICES < ROW_LIMIT) ? MAX_VERTICES : ROW_LIMIT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NCOL  = 2 ** COLOR_W;

    localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

    // Sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an edge word
    localparam logic [2:0] S_EDGE  = 3'd1;  // write back the updated row
    localparam logic [2:0] S_ROW   = 3'd2;  // read the row of vertex v
    localparam logic [2:0] S_LOAD  = 3'd3;  // latch earlier neighbors of v
    localparam logic [2:0] S_SCAN  = 3'd4;  // walk u < v, read colors of neighbors
    localparam logic [2:0] S_DRAIN = 3'd5;  // start the color search at color 0
    localparam logic [2:0] S_FIND  = 3'd6;  // search the smallest free color

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_vcount, n_vcount;
    logic [AW-1:0]      r_hi, n_hi;
    logic [AW-1:0]      r_lo, n_lo;
    logic               r_edge_ok, n_edge_ok;
    logic               r_last, n_last;
    logic [DEPTH-1:0]   r_valid, n_valid;
    logic [AW-1:0]      r_v, n_v;
    logic [AW-1:0]      r_u, n_u;
    logic [DEPTH-1:0]   r_nbrs, n_nbrs;
    logic               r_pend, n_pend;
    logic [NCOL-1:0]    r_used, n_used;
    logic [COLOR_W-1:0] r_c, n_c;
    logic [COLOR_W-1:0] r_top, n_top;
    logic               r_strobe, n_strobe;
    logic [VTX_W-1:0]   r_out_idx, n_out_idx;
    logic [COLOR_W-1:0] r_out_color, n_out_color;
    logic [CNT_W-1:0]   r_out_count, n_out_count;
    logic               r_out_last, n_out_last;

    logic [CNT_W-1:0]   act_cnt;
    logic               edge_ok;
    logic [VTX_W-1:0]   in_hi_full, in_lo_full;
    logic [AW-1:0]      in_hi, in_lo;
    logic               is_last_v;
    logic [COLOR_W-1:0] new_top;

    logic [AW-1:0]      adj_raddr;
    logic               adj_we;
    logic [DEPTH-1:0]   adj_wdata, adj_rdata;
    logic               col_we;
    logic [COLOR_W-1:0] col_rdata;

    // Effective vertex count: zero acts as one, anything above capacity is clipped.
    always_comb begin
        if (r_vcount == '0) begin
            act_cnt = CNT_W'(1);
        end else if (r_vcount > CNT_W'(DEPTH)) begin
            act_cnt = CNT_W'(DEPTH);
        end else begin
            act_cnt = r_vcount;
        end
    end

    // Keep only the lower triangle: the bit of the smaller endpoint lands in the
    // row of the larger one, which is exactly the set of earlier neighbors.
    assign edge_ok    = (i_vertex_a != i_vertex_b) &&
                        (CNT_W'(i_vertex_a) < act_cnt) && (CNT_W'(i_vertex_b) < act_cnt);
    assign in_hi_full = (i_vertex_a > i_vertex_b) ? i_vertex_a : i_vertex_b;
    assign in_lo_full = (i_vertex_a > i_vertex_b) ? i_vertex_b : i_vertex_a;
    assign in_hi      = AW'(in_hi_full);
    assign in_lo      = AW'(in_lo_full);

    assign is_last_v = ((CNT_W'(r_v) + CNT_W'(1)) == act_cnt);
    assign new_top   = (r_c > r_top) ? r_c : r_top;

    always_comb begin
        n_state     = r_state;
        n_vcount    = r_vcount;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_edge_ok   = r_edge_ok;
        n_last      = r_last;
        n_valid     = r_valid;
        n_v         = r_v;
        n_u         = r_u;
        n_nbrs      = r_nbrs;
        n_pend      = 1'b0;
        n_used      = r_used;
        n_c         = r_c;
        n_top       = r_top;
        n_strobe    = 1'b0;
        n_out_idx   = r_out_idx;
        n_out_color = r_out_color;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;

        adj_raddr = r_v;
        adj_we    = 1'b0;
        // A row without its valid bit holds stale data and counts as empty.
        adj_wdata = (r_valid[r_hi] ? adj_rdata : '0) | (DEPTH'(1) << r_lo);
        col_we    = 1'b0;

        // Mark the color of the neighbor read in the previous cycle as taken.
        if (r_pend) begin
            n_used[col_rdata] = 1'b1;
        end

        if (i_cfg_valid && o_cfg_ready) begin
            n_vcount = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                // Read the target row straight off the inputs, so it is on the RAM output in S_EDGE.
                adj_raddr = in_hi;
                if (start) begin
                    n_hi      = in_hi;
                    n_lo      = in_lo;
                    n_edge_ok = edge_ok;
                    n_last    = i_last_edge;
                    n_state   = S_EDGE;
                end
            end
            S_EDGE: begin
                if (r_edge_ok) begin
                    adj_we         = 1'b1;
                    n_valid[r_hi]  = 1'b1;
                end
                if (r_last) begin
                    n_v     = '0;
                    n_top   = '0;
                    n_state = S_ROW;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROW: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_nbrs  = r_valid[r_v] ? adj_rdata : '0;
                n_used  = '0;
                n_u     = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_u == r_v) begin
                    n_state = S_DRAIN;
                end else begin
                    n_pend = r_nbrs[r_u];
                    n_u    = r_u + 1'b1;
                end
            end
            S_DRAIN: begin
                n_c     = '0;
                n_state = S_FIND;
            end
            S_FIND: begin
                if (!r_used[r_c] || (r_c == COLOR_MAX)) begin
                    col_we      = 1'b1;
                    n_top       = new_top;
                    n_strobe    = 1'b1;
                    n_out_idx   = VTX_W'(r_v);
                    n_out_color = r_c;
                    n_out_last  = is_last_v;
                    n_out_count = is_last_v ? (CNT_W'(new_top) + CNT_W'(1)) : '0;
                    if (is_last_v) begin
                        // Drop the whole matrix for the next graph.
                        n_valid = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_v     = r_v + 1'b1;
                        n_state = S_ROW;
                    end
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= CNT_W'(VCOUNT_RST);
            r_valid  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vcount <= n_vcount;
            r_valid  <= n_valid;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi        <= n_hi;
        r_lo        <= n_lo;
        r_edge_ok   <= n_edge_ok;
        r_last      <= n_last;
        r_v         <= n_v;
        r_u         <= n_u;
        r_nbrs      <= n_nbrs;
        r_used      <= n_used;
        r_c         <= n_c;
        r_top       <= n_top;
        r_out_idx   <= n_out_idx;
        r_out_color <= n_out_color;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    // Lower-triangle adjacency rows
    gcc_ram #(
        .WIDTH (DEPTH),
        .DEPTH (DEPTH)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (r_hi),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    // Colors assigned in the current pass; only entries below v are ever used.
    gcc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_v),
        .i_wdata (r_c),
        .i_raddr (r_u),
        .o_rdata (col_rdata)
    );

    assign busy           = (r_state != S_IDLE);
    // Hold off count writes while a word is in flight or being offered.
    assign o_cfg_ready    = !busy && !start;
    assign o_strobe       = r_strobe;
    assign o_vertex_index = r_out_idx;
    assign o_vertex_color = r_out_color;
    assign o_color_count  = r_out_count;
    assign o_last_result  = r_out_last;

    // The final result leaves the block idle with an empty matrix.
    `ASSERT_IMP(a_final_clears, o_strobe && o_last_result, !busy && (r_valid == '0), "stale state")
    // A free color never lies above the vertex index.
    `ASSERT_IMP(a_color_bound, r_state == S_FIND, r_c <= COLOR_W'(r_v), "color past vertex index")
    // Results of one pass never come on adjacent cycles.
    `ASSERT_NEXT(a_strobe_gap, o_strobe && !o_last_result, !o_strobe, "strobes back to back")

endmodule

`default_nettype wire

// ===== sim/tb_greedy_graph_coloring_core.sv =====
module tb_greedy_graph_coloring_core;

    import gcc_pkg::*;

    localparam int CYCLE_LIMIT   = 8_000_000;  // generous watchdog over the whole run
    localparam int SETTLE_CYCLES = 16;         // quiet cycles before a count write
    localparam int TAIL_CYCLES   = 64;         // quiet cycles after the last result
    localparam int RANDOM_WORDS  = 239;        // minimum edge words in the random part
    localparam int SCRIPT_ROWS   = 28;
    localparam int VMAX          = (MAX_VERTICES_DEF < ROW_LIMIT) ? MAX_VERTICES_DEF : ROW_LIMIT;

    // One result word as the block reports it.
    typedef struct {
        logic [VTX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_color_word;

    // Directed script: either a vertex count write or an edge word.
    typedef enum logic {ROW_COUNT, ROW_EDGE} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [CNT_W-1:0] count;   // value written by a count row
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic             last;
        logic [CNT_W-1:0] typed;   // typed color count of the final word, 0 = predictor only
    } t_script_row;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic [VTX_W-1:0]   i_vertex_a     = '0;
    logic [VTX_W-1:0]   i_vertex_b     = '0;
    logic               i_last_edge    = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [CNT_W-1:0]   i_cfg_data     = '0;
    logic               o_strobe;
    logic [VTX_W-1:0]   o_vertex_index;
    logic [COLOR_W-1:0] o_vertex_color;
    logic [CNT_W-1:0]   o_color_count;
    logic               o_last_result;

    greedy_graph_coloring_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_vertex_a     (i_vertex_a),
        .i_vertex_b     (i_vertex_b),
        .i_last_edge    (i_last_edge),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_vertex_index (o_vertex_index),
        .o_vertex_color (o_vertex_color),
        .o_color_count  (o_color_count),
        .o_last_result  (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Shadow copy of the graph held by the block.
    logic [63:0]        adj_rows      [64];
    logic [COLOR_W-1:0] vertex_colors [64];
    logic [63:0]        done_marks;
    logic [CNT_W-1:0]   model_count;

    t_color_word color_queue[$];   // colorings still owed by the block
    int          mismatches = 0;
    int          cycles     = 0;
    int          idle_pct   = 36;

    function automatic int live_vertices();
        int n;
        n = model_count;
        if (n == 0) n = 1;
        if (n > VMAX) n = VMAX;
        return n;
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < 64; i++) begin
            adj_rows[i]      = '0;
            vertex_colors[i] = '0;
        end
        done_marks = '0;
    endfunction

    // Store one edge word; on the last edge, color greedily in index order and
    // queue one result word per live vertex.
    function automatic void take_edge(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                                      input logic last);
        int          n;
        int          c;
        int          top;
        logic [63:0] nbrs;
        logic [63:0] used;
        t_color_word w;
        n = live_vertices();
        // Drop self-loops and edges that leave the live range.
        if (a != b && int'(a) < n && int'(b) < n) begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
        end
        if (!last) return;
        top = 0;
        for (int v = 0; v < n; v++) begin
            // Only neighbors colored earlier in this pass count.
            nbrs = adj_rows[v] & done_marks;
            used = '0;
            for (int u = 0; u < n; u++)
                if (nbrs[u]) used[vertex_colors[u]] = 1'b1;
            c = 0;
            while (c < 63 && used[c]) c++;
            vertex_colors[v] = COLOR_W'(c);
            done_marks[v]    = 1'b1;
            if (c > top) top = c;
        end
        for (int v = 0; v < n; v++) begin
            w.index = VTX_W'(v);
            w.color = vertex_colors[v];
            w.count = (v + 1 == n) ? CNT_W'(top + 1) : '0;
            w.last  = (v + 1 == n);
            color_queue.push_back(w);
        end
        clear_graph();
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0d, want %0d", cycles, what, got, want);
        mismatches++;
    endtask

    // Offer one edge word after a random gap; leave start high once it is taken,
    // so a back-to-back word needs no second assignment in the same step.
    task automatic send_edge(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                             input logic last);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_vertex_a  <= a;
        i_vertex_b  <= b;
        i_last_edge <= last;
        do @(posedge i_clk); while (busy);
        take_edge(a, b, last);
    endtask

    // Drop start, hold until every owed word has come and the block settles.
    task automatic drain();
        start <= 1'b0;
        while (color_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the vertex count once the block is idle.
    task automatic write_count(input logic [CNT_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_count  = value;
    endtask

    // Watchdog: a hung handshake or a missing word ends up here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_greedy_graph_coloring_core: errors");
            $finish;
        end
    end

    // Compare every strobed word with the oldest owed coloring.
    always @(posedge i_clk) begin : check_results
        t_color_word want;
        if (i_rst_n && o_strobe) begin
            if (color_queue.size() == 0) begin
                note_mismatch("unexpected word, index", o_vertex_index, -1);
            end else begin
                want = color_queue.pop_front();
                if (o_vertex_index !== want.index)
                    note_mismatch("vertex_index", o_vertex_index, want.index);
                if (o_vertex_color !== want.color)
                    note_mismatch("vertex_color", o_vertex_color, want.color);
                if (o_color_count !== want.count)
                    note_mismatch("color_count", o_color_count, want.count);
                if (o_last_result !== want.last)
                    note_mismatch("last_result", o_last_result, want.last);
            end
        end
    end

    initial begin : stimulus
        t_script_row      script [SCRIPT_ROWS];
        int               random_words;
        int               phase;
        int               n;
        int               k;
        int               r;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic             last;
        logic [CNT_W-1:0] value;

        script = '{
            // after reset, 64 vertices: one edge gives two colors
            '{ROW_EDGE,  7'd0,   6'd0,  6'd1,  1'b1, 7'd2},
            '{ROW_COUNT, 7'd1,   6'd0,  6'd0,  1'b0, 7'd0},
            // self-loop on the last edge still starts coloring
            '{ROW_EDGE,  7'd0,   6'd0,  6'd0,  1'b1, 7'd1},
            '{ROW_EDGE,  7'd0,   6'd63, 6'd63, 1'b1, 7'd1},
            // count of zero acts as one; endpoint 1 is out of range
            '{ROW_COUNT, 7'd0,   6'd0,  6'd0,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd0,  6'd1,  1'b1, 7'd1},
            // count above the capacity clamps to 64: triangle at the top end
            '{ROW_COUNT, 7'd127, 6'd0,  6'd0,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd63, 6'd0,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd0,  6'd63, 1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd63, 6'd62, 1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd62, 6'd0,  1'b1, 7'd3},
            '{ROW_COUNT, 7'd64,  6'd0,  6'd0,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd5,  6'd5,  1'b1, 7'd1},
            // path with an out-of-range last edge
            '{ROW_COUNT, 7'd3,   6'd0,  6'd0,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd0,  6'd1,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd1,  6'd2,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd2,  6'd3,  1'b1, 7'd0},
            // later neighbors are not yet colored and must not block a color
            '{ROW_COUNT, 7'd5,   6'd0,  6'd0,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd3,  6'd1,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd4,  6'd0,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd2,  6'd4,  1'b1, 7'd0},
            // complete graph on four vertices
            '{ROW_COUNT, 7'd4,   6'd0,  6'd0,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd0,  6'd1,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd0,  6'd2,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd0,  6'd3,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd1,  6'd2,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd1,  6'd3,  1'b0, 7'd0},
            '{ROW_EDGE,  7'd0,   6'd2,  6'd3,  1'b1, 7'd4}
        };

        clear_graph();
        model_count = CNT_W'(VCOUNT_RST);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: walk the script.
        foreach (script[i]) begin
            if (script[i].kind == ROW_COUNT) begin
                write_count(script[i].count);
            end else begin
                send_edge(script[i].a, script[i].b, script[i].last);
                // Pin the final color count where it is obvious by hand.
                if (script[i].last && script[i].typed != 0)
                    color_queue[color_queue.size() - 1].count = script[i].typed;
            end
        end

        // Random part: one graph per phase, mostly small, a few at full size.
        random_words = 0;
        phase        = 0;
        while (random_words < RANDOM_WORDS) begin
            // Hold a stretch of phases with no gaps on the sender.
            idle_pct = (phase >= 8 && phase < 14) ? 0 : 36;
            if (phase == 0 || $urandom_range(99) < 40) begin
                r = $urandom_range(99);
                if (r < 76)      value = CNT_W'($urandom_range(1, 12));
                else if (r < 84) value = CNT_W'(64);
                else if (r < 88) value = '0;
                else if (r < 93) value = CNT_W'($urandom_range(65, 127));
                else             value = CNT_W'($urandom_range(13, 63));
                write_count(value);
            end else if ($urandom_range(99) < 30) begin
                // Pause the sender until the previous coloring is fully out.
                drain();
            end
            n = live_vertices();
            k = $urandom_range(0, (n < 8) ? 2 * n : 14);
            for (int i = 0; i <= k; i++) begin
                last = (i == k);
                r    = $urandom_range(99);
                if (r < 85 && n >= 2) begin
                    a = VTX_W'($urandom_range(0, n - 1));
                    b = VTX_W'((int'(a) + $urandom_range(1, n - 1)) % n);
                end else if (r < 93) begin
                    a = VTX_W'($urandom_range(0, 63));
                    b = a;
                end else begin
                    a = VTX_W'($urandom_range(0, 63));
                    b = VTX_W'($urandom_range((n < 64) ? n : 0, 63));
                end
                random_words++;
                send_edge(a, b, last);
            end
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_greedy_graph_coloring_core: clean");
        else
            $display("tb_greedy_graph_coloring_core: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gcc_pkg.sv
rtl/core/gcc_ram.sv
rtl/core/greedy_graph_coloring_core.sv
sim/tb_greedy_graph_coloring_core.sv
